// ===== design/scsa_pkg.sv =====
// Shared types and constants of the size-class slab allocator.
// No dependencies; scsa_ctrl, scsa_dp and the top level import this package.
package scsa_pkg;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OOM  = 2'd1;
   localparam logic [1:0] STATUS_HALT = 2'd2;

   localparam logic [1:0] KIND_UNUSED     = 2'd0;
   localparam logic [1:0] KIND_SLAB       = 2'd1;
   localparam logic [1:0] KIND_LARGE_HEAD = 2'd2;
   localparam logic [1:0] KIND_LARGE_CONT = 2'd3;

   localparam logic       REG_HEAP_BASE = 1'b0;
   localparam logic [63:0] HEAP_BASE_RESET = 64'hFFFF_FE00_0000_0000;

   localparam logic [31:0] MAX_SLAB_BYTES  = 32'd2048;
   localparam logic [11:0] SLAB_HDR_BYTES  = 12'd32;
   localparam logic [11:0] LARGE_HDR_BYTES = 12'd16;

   // Object slots per slab page for each size class.
   localparam logic [7:0] CLASS_CAP [8] = '{8'd254, 8'd127, 8'd63, 8'd31,
                                           8'd15, 8'd7, 8'd3, 8'd1};

   typedef struct packed {
      logic        op;
      logic [30:0] request_size;
      logic [63:0] free_address;
   } req_type;

   typedef struct packed {
      logic [63:0] result_address;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic set_halt;
      logic set_oom;
      logic walk_start;
      logic walk_rd;
      logic walk_next;
      logic sel_page;
      logic new_start;
      logic init_wr;
      logic new_fin;
      logic pop_rd;
      logic pop_wr;
      logic large_head;
      logic large_mark;
      logic large_fin;
      logic free_rd;
      logic free_slab_wr;
      logic free_rel_start;
      logic free_rel;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       halted;
      logic       op;
      logic       addr_zero;
      logic       is_large;
      logic       large_fits;
      logic       nfp_full;
      logic       pg_ok;
      logic [1:0] kind;
      logic       slab_ok;
      logic       count_nz;
      logic       p_zero;
      logic       init_last;
      logic       mark_done;
      logic       rel_done;
      logic       rsp_free;
   } stat_type;

endpackage

// ===== design/size_class_slab_allocator.sv =====
// Top level of the size-class slab allocator.
// Depends on scsa_pkg, scsa_ctrl, scsa_dp (and scsa_ram through scsa_dp).
//
//   channel   direction  handshake               word
//   req_      in         req_valid / req_ready   req_type (op, request_size, free_address)
//   rsp_      out        rsp_valid / rsp_ready   rsp_type (result_address, status)
//   csr_      in/out     APB, pready tied high   heap_base_address at byte address 0
//
// One request at a time. A slab allocate walks the page chain of its class; one that
// finds no page with a free slot carves a fresh page (one slot link write per cycle).
// A large allocate marks its pages one by one and a large free releases its run page
// by page. The last state repeats while the previous response word waits. Reset is
// synchronous and needs no clearing pass: page records are read only below the bump
// pointer.
module size_class_slab_allocator import scsa_pkg::*; #(
   parameter int HEAP_PAGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type  cmd;
   stat_type st;

   assign csr_pready = 1'b1;

   scsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   scsa_dp #(.HEAP_PAGES(HEAP_PAGES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .st          (st),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // Failed or halted responses never carry an address.
   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.result_address == 64'd0)
      else $error("failed response carries an address");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // Status is one of the three defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_OOM)
                    || (rsp_data.status == STATUS_HALT))
      else $error("undefined status code");
`endif

endmodule

// ===== design/scsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/scsa_ctrl.sv =====
// Sequencing state machine of the slab allocator.
// Depends on scsa_pkg; drives the datapath through cmd_type, reads stat_type.
module scsa_ctrl import scsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_DECIDE = 13'b0000000000010,
      S_WALK   = 13'b0000000000100,
      S_WCHK   = 13'b0000000001000,
      S_NEW    = 13'b0000000010000,
      S_INIT   = 13'b0000000100000,
      S_NFIN   = 13'b0000001000000,
      S_POPRD  = 13'b0000010000000,
      S_POPWR  = 13'b0000100000000,
      S_LMARK  = 13'b0001000000000,
      S_FCHK   = 13'b0010000000000,
      S_FREL   = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.halted) begin
               cmd.set_halt = 1'b1;
               state_in     = S_DONE;
            end else if (st.op == OP_ALLOC) begin
               if (!st.is_large) begin
                  cmd.walk_start = 1'b1;
                  state_in       = S_WALK;
               end else if (st.large_fits) begin
                  cmd.large_head = 1'b1;
                  state_in       = S_LMARK;
               end else begin
                  cmd.set_oom = 1'b1;
                  state_in    = S_DONE;
               end
            end else if (st.addr_zero) begin
               state_in = S_DONE;
            end else if (!st.pg_ok) begin
               cmd.set_halt = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.free_rd = 1'b1;
               state_in    = S_FCHK;
            end
         end
         S_WALK: begin
            if (st.p_zero) begin
               state_in = S_NEW;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = S_WCHK;
            end
         end
         S_WCHK: begin
            if (st.count_nz) begin
               cmd.sel_page = 1'b1;
               state_in     = S_POPRD;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_NEW: begin
            if (st.nfp_full) begin
               cmd.set_oom = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.new_start = 1'b1;
               state_in      = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (st.init_last) begin
               state_in = S_NFIN;
            end
         end
         S_NFIN: begin
            cmd.new_fin = 1'b1;
            state_in    = S_DONE;
         end
         S_POPRD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POPWR;
         end
         S_POPWR: begin
            cmd.pop_wr = 1'b1;
            state_in   = S_DONE;
         end
         S_LMARK: begin
            if (st.mark_done) begin
               cmd.large_fin = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.large_mark = 1'b1;
            end
         end
         S_FCHK: begin
            if (st.kind == KIND_SLAB) begin
               if (st.slab_ok) begin
                  cmd.free_slab_wr = 1'b1;
               end else begin
                  cmd.set_halt = 1'b1;
               end
               state_in = S_DONE;
            end else if (st.kind == KIND_LARGE_HEAD) begin
               cmd.free_rel_start = 1'b1;
               state_in           = S_FREL;
            end else begin
               cmd.set_halt = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_FREL: begin
            if (st.rel_done) begin
               state_in = S_DONE;
            end else begin
               cmd.free_rel = 1'b1;
            end
         end
         S_DONE: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/scsa_dp.sv =====
// Datapath of the slab allocator: heap state, page and slot memories, result word.
// Depends on scsa_pkg and scsa_ram; steered by scsa_ctrl through cmd_type.
module scsa_dp import scsa_pkg::*; #(
   parameter int HEAP_PAGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output stat_type    st,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int PW  = $clog2(HEAP_PAGES + 1);
   localparam int IW  = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
   localparam int CW  = (PW > 8) ? PW : 8;
   localparam int SAW = IW + 8;

   typedef struct packed {
      logic [1:0]    kind;
      logic [2:0]    cls;
      logic [7:0]    count;
      logic [7:0]    head;
      logic [PW-1:0] next;
      logic [PW-1:0] run;
   } page_word_type;

   localparam int PWW = $bits(page_word_type);

   logic [63:0]   base_ff;
   logic          halted_ff;
   logic [PW-1:0] nfp_ff;
   logic [PW-1:0] chain_head_ff [8];
   req_type       req_ff;
   logic [2:0]    cls_ff;
   logic          large_ff;
   logic [19:0]   np_ff;
   logic [PW-1:0] p_ff;
   logic [IW-1:0] idx_ff;
   logic [CW-1:0] cnt_ff;
   page_word_type page_ff;
   logic [63:0]   res_addr_ff;
   logic [1:0]    res_status_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic [63:0]   base_al;
   logic [30:0]   size1;
   logic [2:0]    cls_in;
   logic [31:0]   np_sum;
   logic [63:0]   off;
   logic [IW-1:0] fidx;
   logic [11:0]   pg_off;
   logic [11:0]   w32;
   logic [11:0]   sz12;
   logic [7:0]    fslot;
   logic [7:0]    fcap;
   logic          csr_wr;

   page_word_type page_rd;
   logic [PWW-1:0] page_rd_raw;
   logic           page_we;
   logic [IW-1:0]  page_waddr;
   page_word_type  page_wdata;
   logic           page_re;
   logic [IW-1:0]  page_raddr;

   logic           slot_we;
   logic [SAW-1:0] slot_waddr;
   logic [7:0]     slot_wdata;
   logic [7:0]     slot_rd;

   logic [7:0]     cap;
   logic [7:0]     res_slot;
   logic [11:0]    res_off;
   logic [63:0]    res_addr_slab;

   assign base_al = {base_ff[63:12], 12'h000};
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == REG_HEAP_BASE) ? base_ff : 64'd0;

   // Size class: smallest class whose object size covers the request.
   always_comb begin
      size1  = (req_data.request_size == 31'd0) ? 31'd1 : req_data.request_size;
      cls_in = 3'd7;
      for (int c = 7; c >= 0; c--) begin
         if (32'(size1) <= (32'd16 << c)) begin
            cls_in = 3'(c);
         end
      end
      np_sum = 32'(size1) + 32'd4111;
   end

   // Free address decode.
   assign off    = req_ff.free_address - base_al;
   assign fidx   = off[12 +: IW];
   assign pg_off = off[11:0];
   assign page_rd = page_word_type'(page_rd_raw);
   assign w32    = pg_off - SLAB_HDR_BYTES;
   assign sz12   = 12'd16 << page_rd.cls;
   assign fslot  = 8'(w32 >> ({1'b0, page_rd.cls} + 4'd4));
   assign fcap   = CLASS_CAP[page_rd.cls];

   assign cap = CLASS_CAP[cls_ff];

   always_comb begin
      st            = '0;
      st.halted     = halted_ff;
      st.op         = req_ff.op;
      st.addr_zero  = (req_ff.free_address == 64'd0);
      st.is_large   = large_ff;
      st.large_fits = (32'(np_ff) <= (32'(HEAP_PAGES) - 32'(nfp_ff)));
      st.nfp_full   = (nfp_ff >= PW'(HEAP_PAGES));
      st.pg_ok      = (off[63:12] < 52'(nfp_ff));
      st.kind       = page_rd.kind;
      st.slab_ok    = (pg_off >= SLAB_HDR_BYTES) && ((w32 & (sz12 - 12'd1)) == 12'd0)
                      && (fslot < fcap) && (page_rd.count < fcap);
      st.count_nz   = (page_rd.count != 8'd0);
      st.p_zero     = (p_ff == '0);
      st.init_last  = (cnt_ff[7:0] == cap - 8'd1);
      st.mark_done  = (32'(cnt_ff) >= 32'(np_ff));
      st.rel_done   = (32'(cnt_ff) >= 32'(page_ff.run));
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Result address: page base plus an in-page offset below 4096.
   always_comb begin
      res_slot = cmd.new_fin ? (cap - 8'd1) : page_ff.head;
      res_off  = SLAB_HDR_BYTES + (12'(res_slot) << ({1'b0, cls_ff} + 4'd4));
      if (cmd.large_fin) begin
         res_off = LARGE_HDR_BYTES;
      end
      res_addr_slab = base_al + 64'({idx_ff, res_off});
   end

   // Page record memory ports.
   always_comb begin
      page_re    = cmd.walk_rd || cmd.free_rd;
      page_raddr = cmd.walk_rd ? IW'(p_ff - PW'(1)) : fidx;
      page_we    = 1'b0;
      page_waddr = idx_ff;
      page_wdata = '0;
      if (cmd.new_fin) begin
         page_we          = 1'b1;
         page_wdata.kind  = KIND_SLAB;
         page_wdata.cls   = cls_ff;
         page_wdata.count = cap - 8'd1;
         page_wdata.head  = (cap == 8'd1) ? 8'd0 : (cap - 8'd2);
         page_wdata.next  = chain_head_ff[cls_ff];
      end else if (cmd.pop_wr) begin
         page_we          = 1'b1;
         page_wdata       = page_ff;
         page_wdata.head  = slot_rd;
         page_wdata.count = page_ff.count - 8'd1;
      end else if (cmd.large_head) begin
         page_we         = 1'b1;
         page_waddr      = IW'(nfp_ff);
         page_wdata.kind = KIND_LARGE_HEAD;
         page_wdata.run  = PW'(np_ff);
      end else if (cmd.large_mark) begin
         page_we         = 1'b1;
         page_waddr      = idx_ff + IW'(cnt_ff);
         page_wdata.kind = KIND_LARGE_CONT;
      end else if (cmd.free_slab_wr) begin
         page_we          = 1'b1;
         page_wdata       = page_rd;
         page_wdata.head  = fslot;
         page_wdata.count = page_rd.count + 8'd1;
      end else if (cmd.free_rel) begin
         page_we    = 1'b1;
         page_waddr = idx_ff + IW'(cnt_ff);
      end
   end

   // Slot link memory ports.
   always_comb begin
      slot_we    = 1'b0;
      slot_waddr = {idx_ff, cnt_ff[7:0]};
      slot_wdata = (cnt_ff[7:0] == 8'd0) ? 8'd0 : (cnt_ff[7:0] - 8'd1);
      if (cmd.init_wr) begin
         slot_we = 1'b1;
      end else if (cmd.free_slab_wr) begin
         slot_we    = 1'b1;
         slot_waddr = {idx_ff, fslot};
         slot_wdata = page_rd.head;
      end
   end

   scsa_ram #(.WIDTH(PWW), .DEPTH(HEAP_PAGES)) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (page_waddr),
      .wr_data (page_wdata),
      .rd_en   (page_re),
      .rd_addr (page_raddr),
      .rd_data (page_rd_raw)
   );

   scsa_ram #(.WIDTH(8), .DEPTH(HEAP_PAGES * 256)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (cmd.pop_rd),
      .rd_addr ({idx_ff, page_ff.head}),
      .rd_data (slot_rd)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= HEAP_BASE_RESET;
         halted_ff    <= 1'b0;
         nfp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 8; c++) begin
            chain_head_ff[c] <= '0;
         end
      end else begin
         if (csr_wr && (csr_paddr[3] == REG_HEAP_BASE)) begin
            base_ff <= csr_pwdata;
         end
         if (cmd.set_halt) begin
            halted_ff <= 1'b1;
         end
         if (cmd.new_fin) begin
            nfp_ff                <= nfp_ff + PW'(1);
            chain_head_ff[cls_ff] <= PW'(idx_ff) + PW'(1);
         end
         if (cmd.large_fin) begin
            nfp_ff <= nfp_ff + PW'(np_ff);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the item in flight.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff        <= req_data;
         cls_ff        <= cls_in;
         large_ff      <= (32'(size1) > MAX_SLAB_BYTES);
         np_ff         <= np_sum[31:12];
         res_addr_ff   <= 64'd0;
         res_status_ff <= STATUS_OK;
      end
      if (cmd.set_halt) begin
         res_status_ff <= STATUS_HALT;
      end
      if (cmd.set_oom) begin
         res_status_ff <= STATUS_OOM;
      end
      if (cmd.walk_start) begin
         p_ff <= chain_head_ff[cls_ff];
      end
      if (cmd.walk_next) begin
         p_ff <= page_rd.next;
      end
      if (cmd.sel_page) begin
         idx_ff  <= IW'(p_ff - PW'(1));
         page_ff <= page_rd;
      end
      if (cmd.new_start) begin
         idx_ff <= IW'(nfp_ff);
         cnt_ff <= '0;
      end
      if (cmd.init_wr) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.large_head) begin
         idx_ff <= IW'(nfp_ff);
         cnt_ff <= CW'(1);
      end
      if (cmd.large_mark || cmd.free_rel) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.free_rd) begin
         idx_ff <= fidx;
      end
      if (cmd.free_rel_start) begin
         page_ff <= page_rd;
         cnt_ff  <= '0;
      end
      if (cmd.new_fin || cmd.pop_wr || cmd.large_fin) begin
         res_addr_ff <= res_addr_slab;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.result_address <= res_addr_ff;
         rsp_data_ff.status         <= res_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the size-class slab allocator.
// Needs scsa_pkg and the size_class_slab_allocator design files; nothing else.
`timescale 1ns / 1ps

module testbench import scsa_pkg::*; ;

typedef struct {
   logic [63:0] offset;   // address relative to heap page 0
   bit          is_big;
} held_block_type;

// Shadow copy of the heap bookkeeping plus the queue of expected response words.
class heap_scoreboard;
   logic [63:0]  base;
   bit           halted;
   int unsigned  bump;
   int unsigned  chain_head [8];
   logic [1:0]   kind [1024];
   int unsigned  page_class [1024];
   int unsigned  avail_cnt [1024];
   int unsigned  free_head [1024];
   int unsigned  chain_next [1024];
   int unsigned  run_pages [1024];
   byte unsigned slot_next [];
   rsp_type      pending [$];
   held_block_type held [$];
   logic [63:0]  last_addr;
   int           errors, checked, n_oom, n_halt, n_free, n_large, n_slab;

   function new();
      base = HEAP_BASE_RESET;
      slot_next = new[262144];
      for (int i = 0; i < 1024; i++) kind[i] = KIND_UNUSED;
   endfunction

   function logic [63:0] page_addr(int unsigned idx);
      return {base[63:12], 12'h000} + 64'(idx) * 64'd4096;
   endfunction

   function int unsigned slots_in(int unsigned cls);
      return 4064 / (16 << cls);
   endfunction

   // With commit clear this only tells whether the free would be accepted.
   function logic [1:0] release_object(logic [63:0] addr, bit commit);
      logic [63:0] off;
      int unsigned idx, pg_off, sz, cap, s;
      off = addr - page_addr(0);
      if ((off >> 12) >= 64'(bump)) return STATUS_HALT;
      idx = int'(off >> 12);
      pg_off = off[11:0];
      if (kind[idx] == KIND_SLAB) begin
         sz = 16 << page_class[idx];
         cap = slots_in(page_class[idx]);
         if (pg_off < 32 || (pg_off - 32) % sz != 0) return STATUS_HALT;
         s = (pg_off - 32) / sz;
         if (s >= cap || avail_cnt[idx] >= cap) return STATUS_HALT;
         if (commit) begin
            slot_next[idx * 256 + s] = byte'(free_head[idx]);
            free_head[idx] = s;
            avail_cnt[idx]++;
         end
         return STATUS_OK;
      end
      if (kind[idx] == KIND_LARGE_HEAD) begin
         if (commit)
            for (int i = 0; i < run_pages[idx] && idx + i < 1024; i++)
               kind[idx + i] = KIND_UNUSED;
         return STATUS_OK;
      end
      return STATUS_HALT;
   endfunction

   function logic [1:0] carve_object(logic [30:0] req_size, output logic [63:0] addr);
      logic [63:0] size, pages;
      int unsigned cls, p, idx, steps, s, cap;
      bit found;
      addr = '0;
      size = (req_size == 0) ? 64'd1 : 64'(req_size);
      if (size <= 2048) begin
         cls = 0;
         while ((16 << cls) < size) cls++;
         p = chain_head[cls];
         steps = 0;
         found = 0;
         idx = 0;
         while (p != 0 && steps < 1024) begin
            idx = p - 1;
            if (avail_cnt[idx] != 0) begin
               found = 1;
               break;
            end
            p = chain_next[idx];
            steps++;
         end
         if (!found) begin
            if (bump >= 1024) return STATUS_OOM;
            idx = bump++;
            cap = slots_in(cls);
            kind[idx] = KIND_SLAB;
            page_class[idx] = cls;
            for (int k = 0; k < cap; k++) slot_next[idx * 256 + k] = byte'(k ? k - 1 : 0);
            free_head[idx] = cap - 1;
            avail_cnt[idx] = cap;
            chain_next[idx] = chain_head[cls];
            chain_head[cls] = idx + 1;
         end
         s = free_head[idx];
         free_head[idx] = slot_next[idx * 256 + s];
         avail_cnt[idx]--;
         addr = page_addr(idx) + 64'd32 + 64'(s) * 64'(16 << cls);
         held.push_back('{addr - page_addr(0), 0});
         n_slab++;
         return STATUS_OK;
      end
      pages = (size + 64'd16 + 64'd4095) >> 12;
      if (pages > 64'(1024 - bump)) return STATUS_OOM;
      idx = bump;
      kind[idx] = KIND_LARGE_HEAD;
      run_pages[idx] = int'(pages);
      for (int i = 1; i < pages; i++) kind[idx + i] = KIND_LARGE_CONT;
      bump += int'(pages);
      addr = page_addr(idx) + 64'd16;
      held.push_back('{addr - page_addr(0), 1});
      n_large++;
      return STATUS_OK;
   endfunction

   function void note_request(req_type r);
      rsp_type w;
      w = '0;
      if (halted) begin
         w.status = STATUS_HALT;
      end else if (r.op == OP_ALLOC) begin
         w.status = carve_object(r.request_size, w.result_address);
      end else if (r.free_address != 0) begin
         w.status = release_object(r.free_address, 1);
         if (w.status == STATUS_HALT) halted = 1;
         else n_free++;
      end
      if (w.status == STATUS_OOM) n_oom++;
      if (w.status == STATUS_HALT) n_halt++;
      last_addr = w.result_address;
      pending.push_back(w);
   endfunction

   function void check_result(rsp_type got);
      rsp_type w;
      checked++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response word: addr %h status %0d",
                                    got.result_address, got.status);
         return;
      end
      w = pending.pop_front();
      if (got.result_address !== w.result_address || got.status !== w.status) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on word %0d: expected addr %h status %0d, got addr %h status %0d",
                     checked, w.result_address, w.status, got.result_address, got.status);
      end
   endfunction
endclass

   localparam int          IDLE_LIMIT = 20000;
   localparam logic [3:0]  BASE_ADDR  = 4'(8 * REG_HEAP_BASE);

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   heap_scoreboard sb = new();
   bit calm = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   size_class_slab_allocator dut (.*);

   always #5 clock = ~clock;

   // Response side: random stall bursts, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 400;
         rsp_ready <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send(input req_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic alloc(input int unsigned size);
      req_type r;
      r = '0;
      r.op = OP_ALLOC;
      r.request_size = 31'(size);
      r.free_address = {$urandom, $urandom};
      send(r);
   endtask

   task automatic free_at(input logic [63:0] addr);
      req_type r;
      r.op = OP_FREE;
      r.request_size = 31'($urandom);
      r.free_address = addr;
      send(r);
   endtask

   // Waits for every outstanding response, then leaves the block alone a while.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Reads the base back, rewrites it, then reads it again.
   task automatic set_base(input logic [63:0] value);
      logic [63:0] want;
      want = sb.base;
      for (int pass = 0; pass < 3; pass++) begin
         csr_psel <= 1;
         csr_penable <= 0;
         csr_pwrite <= (pass == 1);
         csr_paddr <= BASE_ADDR;
         csr_pwdata <= value;
         @(posedge clock);
         csr_penable <= 1;
         @(posedge clock);
         if (pass == 1) begin
            sb.base = value;
            want = value;
         end else if (csr_prdata !== want) begin
            sb.errors++;
            if (sb.errors <= 10)
               $display("base register read: expected %h, got %h", want, csr_prdata);
         end
      end
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic random_item();
      req_type     r;
      int unsigned k, cls, j;
      held_block_type b;
      r.op = OP_ALLOC;
      r.free_address = {$urandom, $urandom};
      k = $urandom_range(0, 99);
      if (k < 48) begin
         cls = $urandom_range(0, 7);
         r.request_size = 31'($urandom_range(cls == 0 ? 0 : (8 << cls) + 1, 16 << cls));
      end else if (k < 55) begin
         r.request_size = 31'($urandom_range(2049, 12000));
      end else if (k < 58) begin
         r.request_size = 31'($urandom);
      end else begin
         r.op = OP_FREE;
         if (k < 94 && sb.held.size() > 0) begin
            j = $urandom_range(0, sb.held.size() - 1);
            b = sb.held[j];
            r.free_address = sb.page_addr(0) + b.offset;
            if (b.is_big) r.free_address = r.free_address - 16 + $urandom_range(0, 4095);
            // Now and then the entry is kept, so the same word may be freed twice.
            if ($urandom_range(0, 9) != 0) sb.held.delete(j);
         end else if ($urandom_range(0, 1) == 0) begin
            r.free_address = '0;
         end else begin
            r.free_address = sb.page_addr(0) + 64'($urandom_range(0, sb.bump * 4096));
         end
         if (sb.release_object(r.free_address, 0) == STATUS_HALT) begin
            r.op = OP_ALLOC;
            r.request_size = 31'($urandom_range(0, 2048));
         end
      end
      r.request_size = (r.op == OP_FREE) ? 31'($urandom) : r.request_size;
      send(r);
   endtask

   initial begin
      logic [63:0] a_small, a_big, a_twice;
      logic [63:0] bad;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at the reset base.
      set_base(HEAP_BASE_RESET);
      alloc(0);
      alloc(1);
      alloc(16);
      alloc(17);
      alloc(2048);
      alloc(2049);
      a_big = sb.last_addr;
      alloc(4080);
      alloc(4081);
      alloc(1 << 30);
      alloc(32'h7FFF_FFFF);
      alloc(100);
      a_small = sb.last_addr;
      alloc(100);
      a_twice = sb.last_addr;
      free_at('0);
      free_at(a_twice);
      free_at(a_twice);
      free_at(a_small);
      free_at(a_big + 64'd4000);
      alloc(100);
      alloc(100);
      alloc(100);
      repeat (80) random_item();
      drain();

      set_base('0);
      repeat (40) random_item();
      hold_request = 1;
      repeat (110) random_item();
      drain();

      set_base('1);
      repeat (120) random_item();
      drain();

      set_base({$urandom, $urandom});
      repeat (80) random_item();
      calm = 1;
      repeat (70) random_item();

      // Latch the halt with a bad pointer, then confirm that it sticks.
      do begin
         bad = ($urandom_range(0, 1) == 0) ? sb.page_addr(sb.bump) : {$urandom, $urandom};
      end while (sb.release_object(bad, 0) != STATUS_HALT);
      free_at(bad);
      alloc(16);
      free_at(sb.page_addr(0) + 64'd32);
      alloc(5000);
      drain();
      repeat (300) @(posedge clock);

      $display("covered %0d words: %0d slab and %0d large allocations, %0d frees,",
               sb.checked, sb.n_slab, sb.n_large, sb.n_free);
      $display("%0d out-of-space and %0d halted answers, over four heap base settings",
               sb.n_oom, sb.n_halt);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d words still expected", sb.errors, sb.pending.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// ===== size_class_slab_allocator.f =====
design/scsa_pkg.sv
design/scsa_ram.sv
design/scsa_ctrl.sv
design/scsa_dp.sv
design/size_class_slab_allocator.sv
test/testbench.sv
